[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is asserted.
`define DAYEST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define DAYEST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dayest_pkg.sv]
// Types, constants and helpers for the draft acceptance yield estimator.
package dayest_pkg;

  localparam int FRAC      = 16;
  localparam int MAX_BLOCK = 8;

  localparam logic [16:0] ONE   = 17'h10000;
  localparam logic [15:0] HALF  = 16'h8000;
  localparam logic [16:0] LOG2E = 17'd94548;

  // Multiplier operand and product widths
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LM_WEIGHT    = 2'd0,
    CFG_HAZARD_GAIN  = 2'd1,
    CFG_YIELD_GAIN   = 2'd2,
    CFG_ACCEPT_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [16:0] lm_weight;
    logic [16:0] hazard_gain;
    logic [18:0] yield_gain;
    logic [3:0]  accept_limit;
  } cfg_t;

  typedef struct packed {
    logic [16:0] hazard;
    logic        last_of_run;
    logic [19:0] yield_q;
    logic        status;
  } res_t;

  // Q16 table of 2^-(2^-j), j = 1 is index 0
  function automatic logic [15:0] pow2_neg_k(input logic [3:0] j);
    logic [15:0] k;
    case (j)
      4'd0:    k = 16'd46341;
      4'd1:    k = 16'd55110;
      4'd2:    k = 16'd60097;
      4'd3:    k = 16'd62757;
      4'd4:    k = 16'd64132;
      4'd5:    k = 16'd64830;
      4'd6:    k = 16'd65182;
      4'd7:    k = 16'd65359;
      4'd8:    k = 16'd65447;
      4'd9:    k = 16'd65492;
      4'd10:   k = 16'd65514;
      4'd11:   k = 16'd65525;
      4'd12:   k = 16'd65530;
      4'd13:   k = 16'd65533;
      default: k = 16'd65535;
    endcase
    return k;
  endfunction

  // (p + ONE/2) >> FRAC
  function automatic logic [MUL_P_W-FRAC:0] rnd_q(input logic [MUL_P_W-1:0] p);
    logic [MUL_P_W:0] s;
    s = {1'b0, p} + (MUL_P_W+1)'(HALF);
    return s[MUL_P_W:FRAC];
  endfunction

endpackage

[rtl/dayest_ifs.sv]
// Channel interfaces: input word, result word and configuration writes.
interface dayest_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] log_prob;
  logic        [16:0] winner_mass;
  modport source (output valid, output log_prob, output winner_mass, input ready);
  modport sink   (input valid, input log_prob, input winner_mass, output ready);
endinterface

interface dayest_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] hazard;
  logic        last_of_run;
  logic [19:0] yield_q;
  logic        status;
  modport source (output valid, output hazard, output last_of_run,
                  output yield_q, output status, input ready);
  modport sink   (input valid, input hazard, input last_of_run,
                  input yield_q, input status, output ready);
endinterface

interface dayest_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [dayest_pkg::CFG_IDX_W-1:0]  index;
  logic [dayest_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/dayest_mul.sv]
// Shared multiplier with registered product.
module dayest_mul (
  input  logic                             clk,
  input  logic [dayest_pkg::MUL_A_W-1:0]   a,
  input  logic [dayest_pkg::MUL_B_W-1:0]   b,
  output logic [dayest_pkg::MUL_P_W-1:0]   p_r
);

  always_ff @(posedge clk) begin
    p_r <= dayest_pkg::MUL_P_W'(a) * dayest_pkg::MUL_P_W'(b);
  end

endmodule

[rtl/dayest_core.sv]
// Sequencer and datapath: log/exp evaluation, run state and result register.
module dayest_core (
  input  logic                clk,
  input  logic                rst_n,
  input  dayest_pkg::cfg_t    cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [23:0]  in_log_prob,
  input  logic        [16:0]  in_winner_mass,
  output logic                out_valid,
  input  logic                out_ready,
  output dayest_pkg::res_t    out_res
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_A2   = 16'h0002,
    S_NORM = 16'h0004,
    S_SQ   = 16'h0008,
    S_SQW  = 16'h0010,
    S_TA   = 16'h0020,
    S_TB   = 16'h0040,
    S_TC   = 16'h0080,
    S_EX   = 16'h0100,
    S_EXW  = 16'h0200,
    S_HZ   = 16'h0400,
    S_HZW  = 16'h0800,
    S_SV   = 16'h1000,
    S_YS   = 16'h2000,
    S_YG   = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [23:0] lp_neg_r;
  logic [16:0] x_r;
  logic [4:0]  n_r;
  logic [15:0] frac_r;
  logic [3:0]  cnt_r;
  logic [23:0] a2_r;
  logic [20:0] b2_r;
  logic [41:0] acc_r;
  logic [15:0] f_r;
  logic [9:0]  ti_r;
  logic [16:0] pw_r;
  logic [16:0] hazard_r;
  logic [16:0] survival_r;
  logic [19:0] ysum_r;
  logic [2:0]  depth_r;
  logic        err_r;
  logic [3:0]  lim_r;
  logic        out_valid_r;
  dayest_pkg::res_t res_r;

  logic [dayest_pkg::MUL_A_W-1:0] mul_a;
  logic [dayest_pkg::MUL_B_W-1:0] mul_b;
  logic [dayest_pkg::MUL_P_W-1:0] mul_p;
  logic [dayest_pkg::MUL_P_W-dayest_pkg::FRAC:0] rq;

  logic [16:0] w_eff, omw, g_eff;
  logic        bad, lim_bad;
  logic [19:0] sq;
  logic [42:0] tsum;
  logic [18:0] e_rnd, e_sum;
  logic [16:0] e_val;
  logic        last;
  logic [19:0] lim_q;
  logic [19:0] yv;
  logic        out_fire;

  dayest_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign rq    = dayest_pkg::rnd_q(mul_p);
  assign w_eff = (cfg.lm_weight > dayest_pkg::ONE) ? dayest_pkg::ONE : cfg.lm_weight;
  assign omw   = dayest_pkg::ONE - w_eff;
  assign g_eff = (cfg.hazard_gain > dayest_pkg::ONE) ? dayest_pkg::ONE : cfg.hazard_gain;

  // Input checks
  assign bad     = (!in_log_prob[23] && (in_log_prob != 24'sd0)) ||
                   (in_winner_mass == 17'd0) || (in_winner_mass > dayest_pkg::ONE);
  assign lim_bad = (cfg.accept_limit < 4'd2) ||
                   (cfg.accept_limit > 4'(dayest_pkg::MAX_BLOCK));

  // Squaring step result
  assign sq   = mul_p[35:16];
  // Mixed exponent t, rounded
  assign tsum = {1'b0, acc_r} + 43'(mul_p[41:0]) + 43'(dayest_pkg::HALF);

  // 2^-i with round half up; zero once the shift clears all bits
  always_comb begin
    e_rnd = (ti_r == 10'd0) ? 19'd0 : (19'd1 << (ti_r[4:0] - 5'd1));
    e_sum = 19'(pw_r) + e_rnd;
    if (ti_r >= 10'd18) begin
      e_val = 17'd0;
    end else begin
      e_val = 17'(e_sum >> ti_r[4:0]);
    end
  end

  assign last     = ({1'b0, depth_r} + 4'd1) >= (lim_r - 4'd1);
  assign lim_q    = {lim_r, 16'b0};
  assign out_fire = !out_valid_r || out_ready;

  // Clamped yield
  always_comb begin
    if (rq[22:0] < 23'(dayest_pkg::ONE)) begin
      yv = 20'(dayest_pkg::ONE);
    end else if (rq[22:0] > 23'(lim_q)) begin
      yv = lim_q;
    end else begin
      yv = rq[19:0];
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_a = lp_neg_r;
    mul_b = 21'(dayest_pkg::LOG2E);
    unique case (state_r) inside
      S_SQ, S_SQW: begin
        mul_a = 24'(x_r);
        mul_b = 21'(x_r);
      end
      S_TA: begin
        mul_a = a2_r;
        mul_b = 21'(w_eff);
      end
      S_TB, S_TC: begin
        mul_a = 24'(omw);
        mul_b = b2_r;
      end
      S_EX, S_EXW: begin
        mul_a = 24'(pw_r);
        mul_b = 21'(dayest_pkg::pow2_neg_k(cnt_r));
      end
      S_HZ, S_HZW: begin
        mul_a = 24'(e_val);
        mul_b = 21'(g_eff);
      end
      S_SV, S_YS: begin
        mul_a = 24'(survival_r);
        mul_b = 21'(hazard_r);
      end
      S_YG, S_OUT: begin
        mul_a = 24'(ysum_r);
        mul_b = 21'(cfg.yield_gain);
      end
      default: begin
        mul_a = lp_neg_r;
        mul_b = 21'(dayest_pkg::LOG2E);
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = bad ? S_SV : S_A2;
      S_A2:   state_nxt = S_NORM;
      S_NORM: if (x_r[16]) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SQW;
      S_SQW:  state_nxt = (cnt_r == 4'd15) ? S_TA : S_SQ;
      S_TA:   state_nxt = S_TB;
      S_TB:   state_nxt = S_TC;
      S_TC:   state_nxt = S_EX;
      S_EX: begin
        if (f_r[4'd15 - cnt_r]) state_nxt = S_EXW;
        else if (cnt_r == 4'd15) state_nxt = S_HZ;
      end
      S_EXW:  state_nxt = (cnt_r == 4'd15) ? S_HZ : S_EX;
      S_HZ:   state_nxt = S_HZW;
      S_HZW:  state_nxt = S_SV;
      S_SV:   state_nxt = S_YS;
      S_YS:   state_nxt = S_YG;
      S_YG:   state_nxt = S_OUT;
      S_OUT:  if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      survival_r  <= dayest_pkg::ONE;
      ysum_r      <= 20'(dayest_pkg::ONE);
      depth_r     <= 3'd0;
      err_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Result word held until taken
      if (state_r == S_OUT && out_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == S_IDLE && in_valid) begin
        err_r <= err_r | bad | lim_bad;
      end
      if (state_r == S_YS) begin
        survival_r <= rq[16:0];
        ysum_r     <= ysum_r + 20'(rq[16:0]);
      end
      if (state_r == S_OUT && out_fire) begin
        if (last) begin
          survival_r <= dayest_pkg::ONE;
          ysum_r     <= 20'(dayest_pkg::ONE);
          depth_r    <= 3'd0;
          err_r      <= 1'b0;
        end else begin
          depth_r <= depth_r + 3'd1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        lp_neg_r <= 24'(-in_log_prob);
        x_r      <= in_winner_mass;
        n_r      <= 5'd0;
        frac_r   <= 16'd0;
        cnt_r    <= 4'd0;
        hazard_r <= 17'd0;
        if (cfg.accept_limit < 4'd2) lim_r <= 4'd2;
        else if (lim_bad) lim_r <= 4'(dayest_pkg::MAX_BLOCK);
        else lim_r <= cfg.accept_limit;
      end
      S_NORM: begin
        a2_r <= rq[23:0];
        if (!x_r[16]) begin
          x_r <= {x_r[15:0], 1'b0};
          n_r <= n_r + 5'd1;
        end
      end
      S_SQW: begin
        if (sq >= 20'h20000) begin
          x_r    <= sq[17:1];
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          x_r    <= sq[16:0];
          frac_r <= {frac_r[14:0], 1'b0};
        end
        cnt_r <= cnt_r + 4'd1;
      end
      S_TA: b2_r <= {n_r, 16'b0} - 21'(frac_r);
      S_TB: acc_r <= mul_p[41:0];
      S_TC: begin
        f_r   <= tsum[31:16];
        ti_r  <= tsum[41:32];
        pw_r  <= dayest_pkg::ONE;
        cnt_r <= 4'd0;
      end
      S_EX: if (!f_r[4'd15 - cnt_r]) cnt_r <= cnt_r + 4'd1;
      S_EXW: begin
        pw_r  <= rq[16:0];
        cnt_r <= cnt_r + 4'd1;
      end
      S_HZW: hazard_r <= (rq > 30'(dayest_pkg::ONE)) ? dayest_pkg::ONE : rq[16:0];
      S_OUT: begin
        if (out_fire) begin
          res_r.hazard      <= hazard_r;
          res_r.last_of_run <= last;
          res_r.yield_q     <= (last && !err_r) ? yv : 20'd0;
          res_r.status      <= err_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

[rtl/draft_acceptance_yield_estimator_top.sv]
// Top level: configuration registers, channel wiring and the estimator core.
// A valid word is normalized, then run through repeated squaring for the mass log and
// through the exponent bits, all on one shared multiplier; an invalid word skips to
// the survival and yield steps. Words are taken one at a time: the next is accepted
// only once the last result is stored, and a result not yet taken holds off the store.
// Sync active-low reset clears run state and loads defaults.
module draft_acceptance_yield_estimator_top (
  input  logic         clk,
  input  logic         rst_n,
  dayest_in_if.sink    in_if,
  dayest_out_if.source out_if,
  dayest_cfg_if.sink   cfg_if
);

  dayest_pkg::cfg_t cfg_r;
  dayest_pkg::res_t res;

  assign cfg_if.ready = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lm_weight    <= 17'd0;
      cfg_r.hazard_gain  <= dayest_pkg::ONE;
      cfg_r.yield_gain   <= 19'(dayest_pkg::ONE);
      cfg_r.accept_limit <= 4'(dayest_pkg::MAX_BLOCK);
    end else if (cfg_if.valid) begin
      unique case (dayest_pkg::cfg_idx_t'(cfg_if.index))
        dayest_pkg::CFG_LM_WEIGHT:    cfg_r.lm_weight    <= cfg_if.data[16:0];
        dayest_pkg::CFG_HAZARD_GAIN:  cfg_r.hazard_gain  <= cfg_if.data[16:0];
        dayest_pkg::CFG_YIELD_GAIN:   cfg_r.yield_gain   <= cfg_if.data[18:0];
        dayest_pkg::CFG_ACCEPT_LIMIT: cfg_r.accept_limit <= cfg_if.data[3:0];
        default: begin
        end
      endcase
    end
  end

  dayest_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_log_prob    (in_if.log_prob),
    .in_winner_mass (in_if.winner_mass),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_res        (res)
  );

  assign out_if.hazard      = res.hazard;
  assign out_if.last_of_run = res.last_of_run;
  assign out_if.yield_q     = res.yield_q;
  assign out_if.status      = res.status;

endmodule

[rtl/dayest_chk.sv]
// Port-level checker for the estimator, bound to the top level.
`include "assert_macros.svh"

module dayest_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] hazard,
  input logic        last_of_run,
  input logic [19:0] yield_q,
  input logic        status
);

  // Result word holds while stalled
  `DAYEST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  // Hazard never exceeds one
  `DAYEST_ASSERT(a_hazard_max, out_valid |-> hazard <= 17'h10000, "hazard above one")
  // Yield only on the final depth of a clean run
  `DAYEST_ASSERT(a_yield_zero,
                 out_valid && (!last_of_run || status) |-> yield_q == 20'd0,
                 "yield outside final depth")
  // Reported yield is at least one on a clean final depth
  `DAYEST_ASSERT(a_yield_min,
                 out_valid && last_of_run && !status |-> yield_q >= 20'h10000,
                 "yield below one")
  // Reset leaves no result pending
  `DAYEST_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind draft_acceptance_yield_estimator_top dayest_chk u_dayest_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .hazard      (out_if.hazard),
  .last_of_run (out_if.last_of_run),
  .yield_q     (out_if.yield_q),
  .status      (out_if.status)
);

[bench/tb.sv]
// Self-checking testbench for the draft acceptance yield estimator.
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst_n;

  dayest_in_if  in_ch();
  dayest_out_if out_ch();
  dayest_cfg_if cfg_ch();

  draft_acceptance_yield_estimator_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #10 clk = ~clk;

  // Q16 steps of 2^-(2^-j), j = 1 first
  localparam longint unsigned EXP_STEP [16] = '{
    46341, 55110, 60097, 62757, 64132, 64830, 65182, 65359,
    65447, 65492, 65514, 65525, 65530, 65533, 65535, 65535
  };
  localparam longint unsigned Q1 = 65536;

  // register shadow and run state
  longint unsigned lm_w, haz_g, yld_g, acc_lim;
  longint unsigned surv, ysum, depth;
  bit              run_bad;

  dayest_pkg::res_t expected_words[$];
  int   n_fail, n_words, n_lasts, n_bad_words, n_sent;
  int   send_idle_pct, recv_stall_pct;
  int   hold_seq;

  function automatic longint unsigned qmul(input longint unsigned a, b);
    return (a * b + Q1 / 2) >> 16;
  endfunction

  // -log2(m/ONE) by normalize and repeated squaring
  function automatic longint unsigned mass_log2(input longint unsigned m);
    longint unsigned x, n, fr;
    x = m; n = 0; fr = 0;
    while (x < Q1) begin
      x = x << 1;
      n++;
    end
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 16;
      fr = fr << 1;
      if (x >= 2 * Q1) begin
        x = x >> 1;
        fr = fr | 1;
      end
    end
    return n * Q1 - fr;
  endfunction

  // 2^(-t) in Q16
  function automatic longint unsigned exp2_neg(input longint unsigned t);
    longint unsigned ip, p;
    ip = t >> 16;
    p = Q1;
    for (int j = 1; j <= 16; j++)
      if (t[16-j]) p = qmul(p, EXP_STEP[j-1]);
    if (ip >= 40) return 0;
    return (p + ((64'd1 << ip) >> 1)) >> ip;
  endfunction

  // one depth of evidence: hazard, survival/yield update, run end
  function automatic dayest_pkg::res_t depth_step(input logic [23:0] lp_raw,
                                                  input logic [16:0] m);
    longint            lp;
    longint unsigned   lim, hz, yv, a2, b2, w, g, t;
    bit                bad, last;
    dayest_pkg::res_t  r;
    lp = longint'($signed(lp_raw));
    lim = acc_lim;
    hz = 0;
    yv = 0;
    bad = (lp > 0) || (m == 0) || (m > Q1);
    if (lim < 2 || lim > dayest_pkg::MAX_BLOCK) begin
      run_bad = 1;
      lim = (lim < 2) ? 2 : dayest_pkg::MAX_BLOCK;
    end
    if (!bad) begin
      a2 = qmul(longint'(-lp), 94548);
      b2 = mass_log2(m);
      w = (lm_w > Q1) ? Q1 : lm_w;
      g = (haz_g > Q1) ? Q1 : haz_g;
      t = (w * a2 + (Q1 - w) * b2 + Q1 / 2) >> 16;
      hz = qmul(g, exp2_neg(t));
      if (hz > Q1) hz = Q1;
    end else begin
      run_bad = 1;
    end
    surv = qmul(surv, hz);
    ysum = ysum + surv;
    last = (depth + 1 >= lim - 1);
    if (last && !run_bad) begin
      yv = qmul(yld_g, ysum);
      if (yv < Q1) yv = Q1;
      if (yv > lim * Q1) yv = lim * Q1;
    end
    r.hazard = hz[16:0];
    r.last_of_run = last;
    r.yield_q = yv[19:0];
    r.status = run_bad;
    if (last) begin
      surv = Q1; ysum = Q1; depth = 0; run_bad = 0;
    end else begin
      depth++;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    dayest_pkg::res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_words++;
      if (out_ch.last_of_run) n_lasts++;
      if (out_ch.status) n_bad_words++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        e = expected_words.pop_front();
        if (out_ch.hazard !== e.hazard) begin
          $error("hazard: expected %0d, got %0d", e.hazard, out_ch.hazard);
          n_fail++;
        end
        if (out_ch.last_of_run !== e.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", e.last_of_run, out_ch.last_of_run);
          n_fail++;
        end
        if (out_ch.yield_q !== e.yield_q) begin
          $error("yield_q: expected %0d, got %0d", e.yield_q, out_ch.yield_q);
          n_fail++;
        end
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          n_fail++;
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    int hold_left, seen_seq;
    if (hold_seq != seen_seq) begin
      seen_seq = hold_seq;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // send one word; typed expectation used when given
  task automatic send_word(input logic [23:0] lp, input logic [16:0] m,
                           input bit typed, input dayest_pkg::res_t want);
    dayest_pkg::res_t p;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.log_prob <= lp;
    in_ch.winner_mass <= m;
    do @(posedge clk); while (!in_ch.ready);
    p = depth_step(lp, m);
    expected_words = {expected_words, (typed ? want : p)};
    n_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // write all four registers back to back
  task automatic write_regs(input longint unsigned v0, v1, v2, v3);
    longint unsigned v [4];
    dayest_pkg::cfg_idx_t idx;
    v = '{v0, v1, v2, v3};
    for (int i = 0; i < 4; i++) begin
      idx = dayest_pkg::cfg_idx_t'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data <= v[i][dayest_pkg::CFG_DATA_W-1:0];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx)
        dayest_pkg::CFG_LM_WEIGHT:    lm_w = v[i] & 64'h1FFFF;
        dayest_pkg::CFG_HAZARD_GAIN:  haz_g = v[i] & 64'h1FFFF;
        dayest_pkg::CFG_YIELD_GAIN:   yld_g = v[i] & 64'h7FFFF;
        dayest_pkg::CFG_ACCEPT_LIMIT: acc_lim = v[i] & 64'hF;
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed evidence, some malformed noise
  task automatic rand_word(output logic [23:0] lp, output logic [16:0] m);
    int r, sel;
    r = $urandom_range(99);
    if (r < 82) begin
      sel = $urandom_range(3);
      case (sel)
        0: lp = 24'(-$urandom_range(0, 65536));
        1: lp = 24'(-$urandom_range(0, 1 << 20));
        2: lp = 24'(-$urandom_range(0, 8388608));
        default: lp = '0;
      endcase
      if ($urandom_range(5) == 0) m = 17'(Q1);
      else m = 17'($urandom_range(1, 65536) >> $urandom_range(0, 16));
      if (m == 17'd0) m = 17'd1;
    end else begin
      lp = 24'($urandom);
      m = 17'($urandom);
    end
  endtask

  typedef struct {
    logic [23:0]      lp;
    logic [16:0]      m;
    bit               typed;
    dayest_pkg::res_t want;
  } stim_row_t;

  // directed rows under reset defaults (run length 7)
  stim_row_t directed [16] = '{
    '{24'sd0,        17'd65536,  1'b1, '{17'd65536, 1'b0, 20'd0, 1'b0}},
    '{24'sd1,        17'd65536,  1'b1, '{17'd0,     1'b0, 20'd0, 1'b1}},
    '{-24'sd8388608, 17'd1,      1'b0, '0},
    '{24'sd0,        17'd0,      1'b1, '{17'd0,     1'b0, 20'd0, 1'b1}},
    '{24'sd8388607,  17'd131071, 1'b1, '{17'd0,     1'b0, 20'd0, 1'b1}},
    '{-24'sd1,       17'd65537,  1'b1, '{17'd0,     1'b0, 20'd0, 1'b1}},
    '{-24'sd65536,   17'd32768,  1'b0, '0},
    '{-24'sd45426,   17'd65536,  1'b0, '0},
    '{-24'sd1,       17'd65536,  1'b0, '0},
    '{24'sd0,        17'd1,      1'b0, '0},
    '{-24'sd1000000, 17'd40000,  1'b0, '0},
    '{24'sd0,        17'd65535,  1'b0, '0},
    '{-24'sd200000,  17'd65536,  1'b0, '0},
    '{24'sd0,        17'd65536,  1'b0, '0},
    '{24'sd0,        17'd65536,  1'b1, '{17'd65536, 1'b0, 20'd0, 1'b0}},
    '{-24'sd8388608, 17'd65536,  1'b0, '0}
  };

  // run limit
  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [23:0] lp;
    logic [16:0] m;
    int n_items, mode;
    longint unsigned c0, c1, c2, c3;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.log_prob = '0; in_ch.winner_mass = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_seq = 0;
    n_fail = 0; n_words = 0; n_lasts = 0; n_bad_words = 0; n_sent = 0;
    lm_w = 0; haz_g = Q1; yld_g = Q1; acc_lim = 8;
    surv = Q1; ysum = Q1; depth = 0; run_bad = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_word(directed[i].lp, directed[i].m, directed[i].typed, directed[i].want);
    wait_drained();

    // random phases; early ones pin register extremes
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin c0 = 0;      c1 = 65536;  c2 = 16384;  c3 = 2;  end
        1: begin c0 = 65536;  c1 = 1;      c2 = 262144; c3 = 8;  end
        2: begin c0 = 131071; c1 = 131071; c2 = 524287; c3 = 0;  end
        3: begin c0 = 32768;  c1 = 0;      c2 = 0;      c3 = 15; end
        4: begin c0 = 0;      c1 = 65536;  c2 = 262144; c3 = 1;  end
        5: begin c0 = 65536;  c1 = 65536;  c2 = 262144; c3 = 9;  end
        default: begin
          c0 = $urandom_range(0, 65536);
          c1 = $urandom_range(1, 65536);
          c2 = $urandom_range(16384, 262144);
          c3 = $urandom_range(2, 8);
        end
      endcase
      write_regs(c0, c1, c2, c3);
      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 51 : (mode == 3) ? 36 : 0;
      recv_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 36 : 0;
      n_items = (ph < 6) ? 60 + $urandom_range(0, 9) : 140 + $urandom_range(0, 9);
      for (int k = 0; k < n_items; k++) begin
        if (ph == 7 && k == 20) hold_seq <= hold_seq + 1;
        if (ph == 9 && k == n_items / 2) begin
          in_ch.valid <= 1'b0;
          while (expected_words.size() != 0) @(posedge clk);
        end
        rand_word(lp, m);
        send_word(lp, m, 1'b0, '0);
      end
      wait_drained();
    end

    $display("Sent %0d words over 12 register settings; checked %0d results,", n_sent, n_words);
    $display("%0d run ends, %0d words flagged invalid.", n_lasts, n_bad_words);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
